>>> rtl/csp_pkg.sv
// csp_pkg: shared widths, config/job types and rounding helper for the
// cylinder surface projection block. No dependencies.
`default_nettype none
package csp_pkg;

    localparam int COORD_W    = 32;
    localparam int MAX_POINTS = 64;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;
    localparam int DIR_W      = 16;
    localparam int RAD_W      = 31;
    localparam int DIFF_W     = 33;
    localparam int DVD_W      = 64;
    localparam int DVS_W      = 32;
    localparam int QUO_W      = 40;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_DIR_X  = 3'd1;
    localparam logic [2:0] REG_DIR_Y  = 3'd2;
    localparam logic [2:0] REG_DIR_Z  = 3'd3;
    localparam logic [2:0] REG_AP_X   = 3'd4;
    localparam logic [2:0] REG_AP_Y   = 3'd5;
    localparam logic [2:0] REG_AP_Z   = 3'd6;

    typedef struct packed {
        logic [RAD_W-1:0]             radius;
        logic [2:0][DIR_W-1:0]        dir;
        logic [2:0][COORD_W-1:0]      ap;
    } cfg_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0]      start;
        logic [2:0][DIFF_W-1:0]       diff;
        logic [IDX_W-1:0]             idx;
        logic [CNT_W-1:0]             cnt;
    } job_t;

    // divide by 2^14, round half away from zero
    function automatic logic signed [52:0] rnd14(input logic signed [52:0] v);
        logic [52:0] m;
        logic [52:0] q;
        m = v[52] ? 53'(-v) : 53'(v);
        q = (m + 53'd8192) >> 14;
        return v[52] ? -$signed(q) : $signed(q);
    endfunction

endpackage
`default_nettype wire

>>> rtl/csp_div.sv
// csp_div: restoring divider, one quotient bit per cycle, 40 bits.
// Uses csp_pkg. Needs dividend[63:40] < divisor.
`default_nettype none
module csp_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [csp_pkg::DVD_W-1:0]   dividend,
    input  wire logic [csp_pkg::DVS_W-1:0]   divisor,
    output logic                             done,
    output logic [csp_pkg::QUO_W-1:0]        quotient
);
    import csp_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [5:0]          cnt_reg;
    logic [DVS_W-1:0]    rem_reg;
    logic [DVS_W-1:0]    dvs_reg;
    logic [QUO_W-1:0]    dq_reg;
    logic [DVS_W:0]      trial;
    logic                take;

    assign trial = {rem_reg, dq_reg[QUO_W-1]};
    assign take  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DVS_W'(dividend[DVD_W-1:QUO_W]);
            dq_reg  <= dividend[QUO_W-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            dq_reg  <= {dq_reg[QUO_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule
`default_nettype wire

>>> rtl/csp_front.sv
// csp_front: accepts requests, clamps the count and issues one job per point.
// Uses csp_pkg. Feeds csp_queue.
`default_nettype none
module csp_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [2:0][csp_pkg::COORD_W-1:0] start_pt,
    input  wire logic [2:0][csp_pkg::COORD_W-1:0] end_pt,
    input  wire logic [csp_pkg::CNT_W-1:0]   count,
    input  wire logic                        q_full,
    output logic                             q_push,
    output csp_pkg::job_t                    q_job
);
    import csp_pkg::*;

    logic                       busy_reg;
    logic [IDX_W-1:0]           i_reg;
    logic [CNT_W-1:0]           n_reg;
    logic [2:0][COORD_W-1:0]    s_reg;
    logic [2:0][DIFF_W-1:0]     d_reg;
    logic [CNT_W-1:0]           n_clamp;
    logic                       accept;
    logic                       is_last;

    assign n_clamp  = (count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count;
    assign accept   = in_valid && !busy_reg;
    assign in_stall = busy_reg;
    assign q_push   = busy_reg && !q_full;
    assign is_last  = ({1'b0, i_reg} + CNT_W'(1)) == n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end
        else if (accept)
        begin
            busy_reg <= n_clamp != '0;
            i_reg    <= '0;
        end
        else if (q_push)
        begin
            if (is_last)
                busy_reg <= 1'b0;
            i_reg <= i_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg <= n_clamp;
            for (int k = 0; k < 3; k++)
            begin
                s_reg[k] <= start_pt[k];
                d_reg[k] <= DIFF_W'($signed({end_pt[k][COORD_W-1], end_pt[k]})
                                  - $signed({start_pt[k][COORD_W-1], start_pt[k]}));
            end
        end
    end

    always_comb
    begin
        q_job.start = s_reg;
        q_job.diff  = d_reg;
        q_job.idx   = i_reg;
        q_job.cnt   = n_reg;
    end

endmodule
`default_nettype wire

>>> rtl/csp_queue.sv
// csp_queue: two-entry job queue between front and back.
// Uses csp_pkg.
`default_nettype none
module csp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire csp_pkg::job_t  push_job,
    input  wire logic           pop,
    output logic                full,
    output logic                empty,
    output csp_pkg::job_t       pop_job
);
    import csp_pkg::*;

    job_t        mem [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign pop_job = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_job;
    end

endmodule
`default_nettype wire

>>> rtl/csp_back.sv
// csp_back: per-point sequencer: interpolation, axial split, normalize,
// square root and radial rescale. Uses csp_pkg and csp_div.
`default_nettype none
module csp_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire csp_pkg::cfg_t               cfg,
    input  wire logic                        q_empty,
    input  wire csp_pkg::job_t               q_job,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [2:0][csp_pkg::COORD_W-1:0] out_point,
    output logic [csp_pkg::IDX_W-1:0]        out_index,
    output logic                             out_on_axis,
    output logic                             out_last
);
    import csp_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_MID_GO   = 13'b0000000000010,
        S_MID_WAIT = 13'b0000000000100,
        S_DOT      = 13'b0000000001000,
        S_TRND     = 13'b0000000010000,
        S_AXIS     = 13'b0000000100000,
        S_CHECK    = 13'b0000001000000,
        S_NORM     = 13'b0000010000000,
        S_SQ       = 13'b0000100000000,
        S_ROOT     = 13'b0001000000000,
        S_Q_GO     = 13'b0010000000000,
        S_Q_WAIT   = 13'b0100000000000,
        S_OUT      = 13'b1000000000000
    } state_t;

    state_t                     state_reg;
    job_t                       job_reg;
    logic [1:0]                 k_reg;
    logic                       neg_reg;
    logic [2:0][COORD_W-1:0]    mid_reg;
    logic signed [50:0]         acc_reg;
    logic signed [36:0]         t_reg;
    logic [2:0][38:0]           a_reg;
    logic [2:0][39:0]           w_reg;
    logic [2:0][39:0]           wm_reg;
    logic [63:0]                sum_reg;
    logic [63:0]                sx_reg;
    logic [63:0]                sres_reg;
    logic [63:0]                sbit_reg;
    logic                       valid_reg;

    logic                       div_start;
    logic [DVD_W-1:0]           div_dvd;
    logic [DVS_W-1:0]           div_dvs;
    logic                       div_done;
    logic [QUO_W-1:0]           div_quo;

    logic signed [DIR_W-1:0]    dir_k;
    logic signed [32:0]         r_k;
    logic signed [40:0]         mid_prod;
    logic [39:0]                mid_mag;
    logic signed [48:0]         dot_p;
    logic signed [52:0]         ax_p;
    logic signed [38:0]         a_k;
    logic signed [39:0]         w_k;
    logic [39:0]                mx;
    logic [61:0]                sq;
    logic [61:0]                qp;
    logic [63:0]                s_try;
    logic [DVS_W-1:0]           len;
    logic signed [40:0]         q_signed;
    logic signed [41:0]         mid_sum;
    logic signed [41:0]         res_sum;
    logic [CNT_W-1:0]           n_p1;
    logic [CNT_W-1:0]           i_p1;
    logic                       last_k;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [41:0] v);
        if (v > 42'sd2147483647)
            return {1'b0, {(COORD_W-1){1'b1}}};
        else if (v < -42'sd2147483648)
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return v[COORD_W-1:0];
    endfunction

    csp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign last_k   = k_reg == 2'd2;
    assign n_p1     = job_reg.cnt + CNT_W'(1);
    assign i_p1     = {1'b0, job_reg.idx} + CNT_W'(1);
    assign dir_k    = $signed(cfg.dir[k_reg]);
    assign r_k      = $signed({mid_reg[k_reg][COORD_W-1], mid_reg[k_reg]})
                    - $signed({cfg.ap[k_reg][COORD_W-1], cfg.ap[k_reg]});
    assign mid_prod = $signed({1'b0, i_p1}) * $signed(job_reg.diff[k_reg]);
    assign mid_mag  = mid_prod[40] ? 40'(-mid_prod) : mid_prod[39:0];
    assign dot_p    = r_k * dir_k;
    assign ax_p     = t_reg * dir_k;
    assign a_k      = 39'(rnd14(ax_p));
    assign w_k      = 40'(r_k) - 40'(a_k);
    assign sq       = wm_reg[k_reg][30:0] * wm_reg[k_reg][30:0];
    assign qp       = wm_reg[k_reg][30:0] * cfg.radius;
    assign len      = sres_reg[DVS_W-1:0];
    assign s_try    = sres_reg + sbit_reg;
    assign q_signed = (state_reg == S_MID_WAIT ? neg_reg : w_reg[k_reg][39])
                    ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign mid_sum  = 42'($signed(job_reg.start[k_reg])) + 42'(q_signed);
    assign res_sum  = 42'($signed(cfg.ap[k_reg])) + 42'($signed(a_reg[k_reg]))
                    + 42'(q_signed);

    always_comb
    begin
        mx = wm_reg[0];
        if (wm_reg[1] > mx)
            mx = wm_reg[1];
        if (wm_reg[2] > mx)
            mx = wm_reg[2];
    end

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = {{(DVD_W-40){1'b0}}, mid_mag} + DVD_W'(n_p1 >> 1);
        div_dvs   = DVS_W'(n_p1);
        if (state_reg == S_MID_GO)
            div_start = 1'b1;
        else if (state_reg == S_Q_GO)
        begin
            div_start = 1'b1;
            div_dvd   = {2'b00, qp} + DVD_W'(len >> 1);
            div_dvs   = len;
        end
    end

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (!q_empty)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_MID_GO;
                    end
                S_MID_GO:
                    state_reg <= S_MID_WAIT;
                S_MID_WAIT:
                    if (div_done)
                    begin
                        k_reg     <= last_k ? 2'd0 : k_reg + 2'd1;
                        state_reg <= last_k ? S_DOT : S_MID_GO;
                    end
                S_DOT:
                begin
                    k_reg <= last_k ? 2'd0 : k_reg + 2'd1;
                    if (last_k)
                        state_reg <= S_TRND;
                end
                S_TRND:
                    state_reg <= S_AXIS;
                S_AXIS:
                begin
                    k_reg <= last_k ? 2'd0 : k_reg + 2'd1;
                    if (last_k)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                    if (w_reg == '0)
                    begin
                        valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_NORM;
                S_NORM:
                    if (mx[39:31] == '0 && mx[30])
                        state_reg <= S_SQ;
                S_SQ:
                begin
                    k_reg <= last_k ? 2'd0 : k_reg + 2'd1;
                    if (last_k)
                        state_reg <= S_ROOT;
                end
                S_ROOT:
                    if (sbit_reg == '0)
                        state_reg <= S_Q_GO;
                S_Q_GO:
                    state_reg <= S_Q_WAIT;
                S_Q_WAIT:
                    if (div_done)
                    begin
                        k_reg <= last_k ? 2'd0 : k_reg + 2'd1;
                        if (last_k)
                        begin
                            valid_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_Q_GO;
                    end
                S_OUT:
                    if (!out_stall)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                job_reg <= q_job;
                acc_reg <= '0;
            end
            S_MID_GO:
                neg_reg <= mid_prod[40];
            S_MID_WAIT:
                if (div_done)
                    mid_reg[k_reg] <= mid_sum[COORD_W-1:0];
            S_DOT:
                acc_reg <= acc_reg + 51'(dot_p);
            S_TRND:
                t_reg <= 37'(rnd14(53'(acc_reg)));
            S_AXIS:
            begin
                a_reg[k_reg] <= a_k;
                w_reg[k_reg] <= w_k;
                wm_reg[k_reg] <= w_k[39] ? 40'(-w_k) : 40'(w_k);
            end
            S_CHECK:
            begin
                out_point   <= mid_reg;
                out_on_axis <= 1'b1;
                out_index   <= job_reg.idx;
                out_last    <= i_p1 == job_reg.cnt;
                sum_reg     <= '0;
            end
            S_NORM:
                if (mx[39:31] != '0)
                begin
                    for (int k = 0; k < 3; k++)
                        wm_reg[k] <= wm_reg[k] >> 1;
                end
                else if (!mx[30])
                begin
                    for (int k = 0; k < 3; k++)
                        wm_reg[k] <= wm_reg[k] << 1;
                end
            S_SQ:
            begin
                sum_reg <= sum_reg + 64'(sq);
                if (last_k)
                begin
                    sx_reg   <= sum_reg + 64'(sq);
                    sres_reg <= '0;
                    sbit_reg <= 64'd1 << 62;
                end
            end
            S_ROOT:
                if (sbit_reg != '0)
                begin
                    if (sx_reg >= s_try)
                    begin
                        sx_reg   <= sx_reg - s_try;
                        sres_reg <= (sres_reg >> 1) + sbit_reg;
                    end
                    else
                        sres_reg <= sres_reg >> 1;
                    sbit_reg <= sbit_reg >> 2;
                end
            S_Q_WAIT:
                if (div_done)
                begin
                    out_point[k_reg] <= sat32(res_sum);
                    out_on_axis      <= 1'b0;
                end
            default:
                ;
        endcase
    end

    assign out_valid = valid_reg;

endmodule
`default_nettype wire

>>> rtl/cylinder_surface_projection.sv
// cylinder_surface_projection: top level with the configuration registers.
// Uses csp_pkg, csp_front, csp_queue, csp_back.
//
// Each request yields point_count interior points (clamped to 64, none for
// zero), each moved radially onto the configured cylinder unless on the axis,
// and delivered in index order with last on the final one. An off-axis point
// takes six passes through the shared bit-serial divider (three for
// interpolation, three for rescaling), a 32-step square root and up to 30
// normalize shifts; an on-axis point only takes the interpolation passes.
// The front accepts the next request once the previous one's jobs are queued.
// The user must write registers only while idle; the block does not enforce it.
`default_nettype none
module cylinder_surface_projection (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [csp_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [csp_pkg::DATA_W-1:0]    pwdata,
    output logic [csp_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [csp_pkg::COORD_W-1:0]   start_x,
    input  wire logic [csp_pkg::COORD_W-1:0]   start_y,
    input  wire logic [csp_pkg::COORD_W-1:0]   start_z,
    input  wire logic [csp_pkg::COORD_W-1:0]   end_x,
    input  wire logic [csp_pkg::COORD_W-1:0]   end_y,
    input  wire logic [csp_pkg::COORD_W-1:0]   end_z,
    input  wire logic [csp_pkg::CNT_W-1:0]     point_count,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [csp_pkg::COORD_W-1:0]        point_x,
    output logic [csp_pkg::COORD_W-1:0]        point_y,
    output logic [csp_pkg::COORD_W-1:0]        point_z,
    output logic [csp_pkg::IDX_W-1:0]          point_index,
    output logic                               on_axis,
    output logic                               last
);
    import csp_pkg::*;

    logic [RAD_W-1:0]           radius_reg;
    logic [2:0][DIR_W-1:0]      dir_reg;
    logic [2:0][COORD_W-1:0]    ap_reg;
    cfg_t                       cfg;
    logic                       wr_en;
    logic [2:0]                 reg_sel;

    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    job_t                       front_job;
    job_t                       back_job;
    logic [2:0][COORD_W-1:0]    out_point;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(65536);
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= DIR_W'(16384);
            ap_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_RADIUS: radius_reg <= pwdata[RAD_W-1:0];
                REG_DIR_X:  dir_reg[0] <= pwdata[DIR_W-1:0];
                REG_DIR_Y:  dir_reg[1] <= pwdata[DIR_W-1:0];
                REG_DIR_Z:  dir_reg[2] <= pwdata[DIR_W-1:0];
                REG_AP_X:   ap_reg[0]  <= pwdata;
                REG_AP_Y:   ap_reg[1]  <= pwdata;
                REG_AP_Z:   ap_reg[2]  <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_RADIUS: prdata = DATA_W'(radius_reg);
            REG_DIR_X:  prdata = DATA_W'($signed(dir_reg[0]));
            REG_DIR_Y:  prdata = DATA_W'($signed(dir_reg[1]));
            REG_DIR_Z:  prdata = DATA_W'($signed(dir_reg[2]));
            REG_AP_X:   prdata = ap_reg[0];
            REG_AP_Y:   prdata = ap_reg[1];
            REG_AP_Z:   prdata = ap_reg[2];
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.radius = radius_reg;
        cfg.dir    = dir_reg;
        cfg.ap     = ap_reg;
    end

    csp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .start_pt ({start_z, start_y, start_x}),
        .end_pt   ({end_z, end_y, end_x}),
        .count    (point_count),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (front_job)
    );

    csp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .pop_job  (back_job)
    );

    csp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_job       (back_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_point   (out_point),
        .out_index   (point_index),
        .out_on_axis (on_axis),
        .out_last    (last)
    );

    assign point_x = out_point[0];
    assign point_y = out_point[1];
    assign point_z = out_point[2];

endmodule
`default_nettype wire

>>> rtl/csp_checker.sv
// csp_checker: port-level checks for cylinder_surface_projection, bound
// to the top level. Uses csp_pkg widths.
`default_nettype none
module csp_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pready,
    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic [csp_pkg::CNT_W-1:0]   point_count,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic [csp_pkg::COORD_W-1:0] point_x,
    input  wire logic [csp_pkg::IDX_W-1:0]   point_index
);

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && point_count != '0 |=> in_stall)
        else $error("request with points not held off");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x)
        && $stable(point_index))
        else $error("stalled result changed");

endmodule

bind cylinder_surface_projection csp_checker u_csp_checker (.*);
`default_nettype wire

>>> tb/cylinder_surface_projection_tb.sv
// Self-checking testbench for cylinder_surface_projection: drives requests and
// APB register writes, predicts every projected point and checks each result.
// Depends on csp_pkg and the cylinder_surface_projection RTL.
`default_nettype none

typedef struct {
    logic [31:0] sx, sy, sz, ex, ey, ez;
    logic [6:0]  cnt;
} seg_req_t;

typedef struct {
    logic [31:0] px, py, pz;
    logic [5:0]  idx;
    logic        axis_flag;
    logic        fin;
} proj_pt_t;

class projection_scoreboard;
    longint unsigned rad;
    longint          dir[3];
    longint          apt[3];
    proj_pt_t        expected_points[$];
    int              errors;

    function new();
        rad = 65536;
        dir[0] = 0; dir[1] = 0; dir[2] = 16384;
        apt[0] = 0; apt[1] = 0; apt[2] = 0;
        errors = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
        case (idx)
            csp_pkg::REG_RADIUS: rad = val[30:0];
            csp_pkg::REG_DIR_X:  dir[0] = longint'($signed(val[15:0]));
            csp_pkg::REG_DIR_Y:  dir[1] = longint'($signed(val[15:0]));
            csp_pkg::REG_DIR_Z:  dir[2] = longint'($signed(val[15:0]));
            csp_pkg::REG_AP_X:   apt[0] = longint'($signed(val));
            csp_pkg::REG_AP_Y:   apt[1] = longint'($signed(val));
            csp_pkg::REG_AP_Z:   apt[2] = longint'($signed(val));
            default: ;
        endcase
    endfunction

    function longint round_div(longint num, longint unsigned den);
        longint unsigned m;
        longint unsigned q;
        m = (num < 0) ? longint'(-num) : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function void note_request(seg_req_t r);
        longint s[3], d[3], mid[3], rr[3], a[3], w[3], t, q;
        longint unsigned wm[3], mx, sq, len;
        int n;
        proj_pt_t p;
        logic [31:0] res[3];
        n = (r.cnt > 64) ? 64 : r.cnt;
        s[0] = $signed(r.sx); s[1] = $signed(r.sy); s[2] = $signed(r.sz);
        d[0] = longint'($signed(r.ex)) - s[0];
        d[1] = longint'($signed(r.ey)) - s[1];
        d[2] = longint'($signed(r.ez)) - s[2];
        for (int i = 0; i < n; i++) begin
            t = 0;
            for (int k = 0; k < 3; k++) begin
                mid[k] = s[k] + round_div(longint'(i + 1) * d[k], n + 1);
                rr[k] = mid[k] - apt[k];
                t += rr[k] * dir[k];
            end
            t = round_div(t, 16384);
            mx = 0;
            for (int k = 0; k < 3; k++) begin
                a[k] = round_div(t * dir[k], 16384);
                w[k] = rr[k] - a[k];
                wm[k] = (w[k] < 0) ? longint'(-w[k]) : w[k];
                if (wm[k] > mx) mx = wm[k];
            end
            p.axis_flag = (mx == 0);
            if (p.axis_flag) begin
                for (int k = 0; k < 3; k++) res[k] = clamp32(mid[k]);
            end else begin
                while (mx >= 64'h8000_0000) begin
                    mx = mx >> 1;
                    for (int k = 0; k < 3; k++) wm[k] = wm[k] >> 1;
                end
                while (mx < 64'h4000_0000) begin
                    mx = mx << 1;
                    for (int k = 0; k < 3; k++) wm[k] = wm[k] << 1;
                end
                sq = 0;
                for (int k = 0; k < 3; k++) sq += wm[k] * wm[k];
                len = root_floor(sq);
                for (int k = 0; k < 3; k++) begin
                    q = longint'((wm[k] * rad + len / 2) / len);
                    if (w[k] < 0) q = -q;
                    res[k] = clamp32(apt[k] + a[k] + q);
                end
            end
            p.px = res[0]; p.py = res[1]; p.pz = res[2];
            p.idx = i[5:0];
            p.fin = (i + 1 == n);
            expected_points.push_back(p);
        end
    endfunction

    function void check_point(proj_pt_t got);
        proj_pt_t e;
        if (expected_points.size() == 0) begin
            errors++;
            $display("%0t: unexpected point idx %0d x %h y %h z %h", $time,
                     got.idx, got.px, got.py, got.pz);
            return;
        end
        e = expected_points.pop_front();
        if (got.px !== e.px || got.py !== e.py || got.pz !== e.pz ||
            got.idx !== e.idx || got.axis_flag !== e.axis_flag || got.fin !== e.fin) begin
            errors++;
            $display("%0t: mismatch exp x %h y %h z %h idx %0d axis %b last %b", $time,
                     e.px, e.py, e.pz, e.idx, e.axis_flag, e.fin);
            $display("%0t:          got x %h y %h z %h idx %0d axis %b last %b", $time,
                     got.px, got.py, got.pz, got.idx, got.axis_flag, got.fin);
        end
    endfunction
endclass

module cylinder_surface_projection_tb;
    import csp_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES = 800;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [31:0] start_x = '0, start_y = '0, start_z = '0;
    logic [31:0] end_x = '0, end_y = '0, end_z = '0;
    logic [6:0] point_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] point_x, point_y, point_z;
    logic [5:0] point_index;
    logic on_axis, last;

    projection_scoreboard sb = new();
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int idle_cycles = 0;

    cylinder_surface_projection DUT (.*);

    always #10 clk = ~clk;

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else if (quiet) begin
                out_stall <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                out_stall <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        proj_pt_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.px = point_x; got.py = point_y; got.pz = point_z;
            got.idx = point_index; got.axis_flag = on_axis; got.fin = last;
            sb.check_point(got);
            idle_cycles = 0;
        end else if (rst_n && in_valid && !in_stall) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("cylinder_surface_projection verification failed");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic write_all(logic [30:0] r, logic [15:0] dx, logic [15:0] dy,
                             logic [15:0] dz, logic [31:0] ax, logic [31:0] ay,
                             logic [31:0] az);
        reg_write(REG_RADIUS, {1'b0, r});
        reg_write(REG_DIR_X, {16'h0, dx});
        reg_write(REG_DIR_Y, {16'h0, dy});
        reg_write(REG_DIR_Z, {16'h0, dz});
        reg_write(REG_AP_X, ax);
        reg_write(REG_AP_Y, ay);
        reg_write(REG_AP_Z, az);
    endtask

    task automatic wait_drained();
        while (sb.expected_points.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // leaves in_valid high after acceptance, save for a random gap it may insert itself; idle_input lowers it
    task automatic send(seg_req_t r);
        start_x <= r.sx; start_y <= r.sy; start_z <= r.sz;
        end_x <= r.ex; end_y <= r.ey; end_z <= r.ez;
        point_count <= r.cnt;
        in_valid <= 1'b1;
        forever begin
            @(negedge clk);
            if (!in_stall) begin
                sb.note_request(r);
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            2: return 32'($signed($urandom_range(0, 134217728)) - 67108864);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1024)) - 512) << 16;
        endcase
    endfunction

    function automatic seg_req_t rand_req();
        seg_req_t r;
        r.sx = rand_coord(); r.sy = rand_coord(); r.sz = rand_coord();
        r.ex = rand_coord(); r.ey = rand_coord(); r.ez = rand_coord();
        case ($urandom_range(0, 19))
            0:  r.cnt = 0;
            1:  r.cnt = 64;
            2:  r.cnt = $urandom_range(65, 127);
            3:  begin r.ex = r.sx; r.ey = r.sy; r.ez = r.sz; r.cnt = 3; end
            4:  begin
                    // segment parallel to z through the axis point; on the axis when the direction is along z
                    r.sx = sb.apt[0][31:0]; r.ex = r.sx;
                    r.sy = sb.apt[1][31:0]; r.ey = r.sy;
                    r.cnt = $urandom_range(1, 5);
                end
            default: r.cnt = $urandom_range(1, 6);
        endcase
        return r;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) send(rand_req());
        idle_input();
    endtask

    task automatic run_directed();
        seg_req_t r;
        r = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 7'd1};
        send(r);
        r = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h0, 7'd2};
        send(r);
        r = '{32'h0, 32'h0, 32'hFFF0_0000, 32'h0, 32'h0, 32'h0010_0000, 7'd3};
        send(r);   // on the axis under the reset configuration
        r = '{32'h0001_0000, 32'h0, 32'h0, 32'h0003_0000, 32'h0, 32'h0, 7'd0};
        send(r);   // no points
        r = '{32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0, 7'd64};
        send(r);
        r = '{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0, 7'd127};
        send(r);   // count clamps to the maximum
        r = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 7'd65};
        send(r);
        r = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hEDCB_A987, 7'd5};
        send(r);
        r = '{32'h0000_0001, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 7'd1};
        send(r);
        idle_input();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();

        write_all(31'h7FFF_FFFF, 16'sd16384, 16'h0, 16'h0,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_3039);
        run_directed();
        // fill the block while the result side holds off
        hold_req = 1'b1;
        run_random(25);
        wait_drained();

        write_all(31'h0, 16'h0, 16'h0, 16'h0,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        reg_write(REG_NONE, 32'hFFFF_FFFF);
        run_random(25);
        wait_drained();

        write_all(31'($urandom()), 16'sd11585, -16'sd11585, 16'hFFFF,
                  $urandom(), $urandom(), $urandom());
        run_random(25);
        // sender pause until everything is out
        while (sb.expected_points.size() != 0) @(posedge clk);
        run_random(20);
        wait_drained();

        write_all(31'h0001_8000, 16'h0, 16'h0, -16'sd16384,
                  32'h0010_0000, 32'hFFF0_0000, 32'h0);
        run_random(20);
        quiet = 1'b1;
        run_random(20);
        wait_drained();

        if (sb.errors == 0 && sb.expected_points.size() == 0)
            $display("cylinder_surface_projection verification clean");
        else
            $display("cylinder_surface_projection verification failed");
        $finish;
    end
endmodule

`default_nettype wire

>>> filelist.f
rtl/csp_pkg.sv
rtl/csp_div.sv
rtl/csp_front.sv
rtl/csp_queue.sv
rtl/csp_back.sv
rtl/cylinder_surface_projection.sv
rtl/csp_checker.sv
tb/cylinder_surface_projection_tb.sv
